/* rtl/albr_pkg.sv */
// ----------------------------------------------------------------------------
// albr_pkg
// Shared widths, constants and transaction structs of the AXI-Lite slave
// bridge.
// ----------------------------------------------------------------------------
package albr_pkg;

  // Field widths of the bus and IP sides
  localparam int FIELD_W = 32;
  localparam int STRB_W  = 4;
  localparam int WAIT_W  = 8;

  // Default address width and read wait count after reset
  localparam int ADDR_WIDTH_DEFAULT = 32;
  localparam logic [WAIT_W-1:0] READ_WAIT_RESET = 8'd2;

  typedef logic [FIELD_W-1:0] word_t;
  typedef logic [STRB_W-1:0]  strb_t;
  typedef logic [WAIT_W-1:0]  wait_t;

  // One clock tick of bus handshake signals and IP read data
  typedef struct packed {
    logic  read_addr_valid;
    word_t read_addr;
    logic  read_ready;
    logic  write_addr_valid;
    word_t write_addr;
    logic  write_data_valid;
    word_t write_data;
    strb_t write_strobes;
    logic  write_resp_ready;
    word_t ip_read_data;
  } item_t;

  // Registered outputs of the read machine
  typedef struct packed {
    logic  read_addr_ready;
    logic  read_data_valid;
    word_t read_data;
    word_t ip_read_addr;
    logic  ip_read_strobe;
  } rd_out_t;

  // Registered outputs of the write machine
  typedef struct packed {
    logic  write_addr_ready;
    logic  write_data_ready;
    logic  write_resp_valid;
    word_t ip_write_addr;
    word_t ip_write_data;
    strb_t ip_write_byte_enables;
    logic  ip_write_strobe;
  } wr_out_t;

endpackage

/* rtl/axi_lite_slave_bridge_top.sv */
// ----------------------------------------------------------------------------
// axi_lite_slave_bridge_top
// AXI-Lite slave to IP register port bridge, one bus tick per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   Each input transaction is one bus clock tick: the AXI-Lite handshake
//   signals from the master plus the IP read data. Each input transaction
//   yields exactly one output transaction: the registered bus and IP port
//   signals after that tick's update of the read and write machines.
//   From input acceptance to output valid, the input register holds the
//   tick, then a step updates the state registers, which drive the outputs
//   directly and raise out_valid.
//   Throughput is one transaction per cycle while out_ready is high; the
//   input register and the state registers form a two-entry pipeline.
//   When the receiver stalls, the outputs hold and the input register takes
//   one more transaction, then in_ready drops until out_ready returns.
//   Reset clears both machines to idle, out_valid and all bus and IP
//   outputs to zero, and sets read_wait_cycles to 2. cfg_write_en writes
//   read_wait_cycles at once; write it only while no transaction is in flight.
// ----------------------------------------------------------------------------
module axi_lite_slave_bridge_top #(
  parameter int ADDR_WIDTH = albr_pkg::ADDR_WIDTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  // configuration
  input  logic                   cfg_write_en,
  input  albr_pkg::wait_t        cfg_write_data,
  // input channel
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   read_addr_valid,
  input  albr_pkg::word_t        read_addr,
  input  logic                   read_ready,
  input  logic                   write_addr_valid,
  input  albr_pkg::word_t        write_addr,
  input  logic                   write_data_valid,
  input  albr_pkg::word_t        write_data,
  input  albr_pkg::strb_t        write_strobes,
  input  logic                   write_resp_ready,
  input  albr_pkg::word_t        ip_read_data,
  // output channel
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   read_addr_ready,
  output logic                   read_data_valid,
  output albr_pkg::word_t        read_data,
  output logic                   write_addr_ready,
  output logic                   write_data_ready,
  output logic                   write_resp_valid,
  output albr_pkg::word_t        ip_read_addr,
  output logic                   ip_read_strobe,
  output albr_pkg::word_t        ip_write_addr,
  output albr_pkg::word_t        ip_write_data,
  output albr_pkg::strb_t        ip_write_byte_enables,
  output logic                   ip_write_strobe
);

  albr_pkg::item_t   item_in;
  albr_pkg::item_t   held_item;
  albr_pkg::rd_out_t rd;
  albr_pkg::wr_out_t wr;
  albr_pkg::wait_t   read_wait_cycles;
  logic              held_valid;
  logic              step;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      read_wait_cycles <= albr_pkg::READ_WAIT_RESET;
    end else if (cfg_write_en) begin
      read_wait_cycles <= cfg_write_data;
    end
  end

  // Pack the tick
  always_comb begin
    item_in.read_addr_valid  = read_addr_valid;
    item_in.read_addr        = read_addr;
    item_in.read_ready       = read_ready;
    item_in.write_addr_valid = write_addr_valid;
    item_in.write_addr       = write_addr;
    item_in.write_data_valid = write_data_valid;
    item_in.write_data       = write_data;
    item_in.write_strobes    = write_strobes;
    item_in.write_resp_ready = write_resp_ready;
    item_in.ip_read_data     = ip_read_data;
  end

  // Machines step when a tick is held and the output slot is free
  assign step = held_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  albr_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .item_in    (item_in),
    .advance    (step),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  albr_read_fsm #(
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_read_fsm (
    .clk              (clk),
    .rst              (rst),
    .step             (step),
    .read_wait_cycles (read_wait_cycles),
    .item             (held_item),
    .rd               (rd)
  );

  albr_write_fsm #(
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_write_fsm (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .item (held_item),
    .wr   (wr)
  );

  // Outputs come straight from the machine registers
  assign read_addr_ready       = rd.read_addr_ready;
  assign read_data_valid       = rd.read_data_valid;
  assign read_data             = rd.read_data;
  assign ip_read_addr          = rd.ip_read_addr;
  assign ip_read_strobe        = rd.ip_read_strobe;
  assign write_addr_ready      = wr.write_addr_ready;
  assign write_data_ready      = wr.write_data_ready;
  assign write_resp_valid      = wr.write_resp_valid;
  assign ip_write_addr         = wr.ip_write_addr;
  assign ip_write_data         = wr.ip_write_data;
  assign ip_write_byte_enables = wr.ip_write_byte_enables;
  assign ip_write_strobe       = wr.ip_write_strobe;

endmodule

/* rtl/albr_in_stage.sv */
// ----------------------------------------------------------------------------
// albr_in_stage
// Input register: holds one tick transaction until the machines consume it.
// ----------------------------------------------------------------------------
module albr_in_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  albr_pkg::item_t item_in,
  input  logic           advance,
  output logic           held_valid,
  output albr_pkg::item_t held_item
);

  // Take a new transaction when empty or when the held one moves on
  assign in_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_item <= item_in;
    end
  end

endmodule

/* rtl/albr_read_fsm.sv */
// ----------------------------------------------------------------------------
// albr_read_fsm
// Read machine: address latch, IP read strobe, wait count, response hold.
// ----------------------------------------------------------------------------
module albr_read_fsm #(
  parameter int ADDR_WIDTH = albr_pkg::ADDR_WIDTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  albr_pkg::wait_t  read_wait_cycles,
  input  albr_pkg::item_t  item,
  output albr_pkg::rd_out_t rd
);

  // Address bits kept: ADDR_WIDTH, capped at the field width
  localparam int ADDR_KEEP = (ADDR_WIDTH < albr_pkg::FIELD_W) ? ADDR_WIDTH
                                                             : albr_pkg::FIELD_W;

  typedef enum logic [2:0] {
    RD_IDLE     = 3'd0,
    RD_REGISTER = 3'd1,
    RD_WAIT     = 3'd2,
    RD_RESPONSE = 3'd3,
    RD_DONE     = 3'd4
  } rd_state_t;

  rd_state_t              state;
  albr_pkg::wait_t        wait_counter;
  logic [ADDR_KEEP-1:0]   latched_read_addr;
  logic [ADDR_KEEP-1:0]   ip_raddr;
  albr_pkg::word_t        captured_read_data;
  logic                   arready;
  logic                   rvalid;
  logic                   ip_rd;

  // State and registered outputs, advanced once per consumed tick
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= RD_IDLE;
      wait_counter       <= '0;
      latched_read_addr  <= '0;
      ip_raddr           <= '0;
      captured_read_data <= '0;
      arready            <= 1'b0;
      rvalid             <= 1'b0;
      ip_rd              <= 1'b0;
    end else if (step) begin
      unique case (state)
        RD_IDLE: begin
          wait_counter <= '0;
          rvalid       <= 1'b0;
          if (item.read_addr_valid) begin
            latched_read_addr <= item.read_addr[ADDR_KEEP-1:0];
            arready           <= 1'b1;
            state             <= RD_REGISTER;
          end
        end
        RD_REGISTER: begin
          arready  <= 1'b0;
          ip_raddr <= latched_read_addr;
          ip_rd    <= 1'b1;
          state    <= RD_WAIT;
        end
        RD_WAIT: begin
          ip_rd              <= 1'b0;
          captured_read_data <= item.ip_read_data;
          // zero wait count wraps the compare value to 255, the longest wait
          if (wait_counter == albr_pkg::wait_t'(read_wait_cycles - 8'd1)) begin
            rvalid <= 1'b1;
            state  <= RD_RESPONSE;
          end else begin
            wait_counter <= wait_counter + 8'd1;
          end
        end
        RD_RESPONSE: begin
          state <= RD_DONE;
        end
        default: begin
          // hold rvalid until the master takes the data
          if (item.read_ready) begin
            rvalid <= 1'b0;
            state  <= RD_IDLE;
          end
        end
      endcase
    end
  end

  always_comb begin
    rd.read_addr_ready = arready;
    rd.read_data_valid = rvalid;
    rd.read_data       = captured_read_data;
    rd.ip_read_addr    = albr_pkg::word_t'(ip_raddr);
    rd.ip_read_strobe  = ip_rd;
  end

endmodule

/* rtl/albr_write_fsm.sv */
// ----------------------------------------------------------------------------
// albr_write_fsm
// Write machine: address and data in either order, one IP write, response.
// ----------------------------------------------------------------------------
module albr_write_fsm #(
  parameter int ADDR_WIDTH = albr_pkg::ADDR_WIDTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  albr_pkg::item_t  item,
  output albr_pkg::wr_out_t wr
);

  localparam int ADDR_KEEP = (ADDR_WIDTH < albr_pkg::FIELD_W) ? ADDR_WIDTH
                                                             : albr_pkg::FIELD_W;

  typedef enum logic [2:0] {
    WR_IDLE       = 3'd0,
    WR_ADDR_FIRST = 3'd1,
    WR_DATA_FIRST = 3'd2,
    WR_UPDATE     = 3'd3,
    WR_DONE       = 3'd4
  } wr_state_t;

  wr_state_t            state;
  logic [ADDR_KEEP-1:0] latched_write_addr;
  albr_pkg::word_t      latched_write_data;
  albr_pkg::strb_t      latched_write_strobes;
  logic [ADDR_KEEP-1:0] ip_waddr;
  albr_pkg::word_t      ip_wdata;
  albr_pkg::strb_t      ip_wbe;
  logic                 awready;
  logic                 wready;
  logic                 bvalid;
  logic                 ip_wr;

  // State and registered outputs, advanced once per consumed tick
  always_ff @(posedge clk) begin
    if (rst) begin
      state                 <= WR_IDLE;
      latched_write_addr    <= '0;
      latched_write_data    <= '0;
      latched_write_strobes <= '0;
      ip_waddr              <= '0;
      ip_wdata              <= '0;
      ip_wbe                <= '0;
      awready               <= 1'b0;
      wready                <= 1'b0;
      bvalid                <= 1'b0;
      ip_wr                 <= 1'b0;
    end else if (step) begin
      unique case (state)
        WR_IDLE: begin
          if (item.write_addr_valid) begin
            latched_write_addr <= item.write_addr[ADDR_KEEP-1:0];
            awready            <= 1'b1;
          end
          if (item.write_data_valid) begin
            latched_write_data    <= item.write_data;
            latched_write_strobes <= item.write_strobes;
            wready                <= 1'b1;
          end
          if (item.write_addr_valid && item.write_data_valid) begin
            state <= WR_UPDATE;
          end else if (item.write_addr_valid) begin
            state <= WR_ADDR_FIRST;
          end else if (item.write_data_valid) begin
            state <= WR_DATA_FIRST;
          end else begin
            awready <= 1'b0;
            wready  <= 1'b0;
            bvalid  <= 1'b0;
            ip_wr   <= 1'b0;
          end
        end
        WR_ADDR_FIRST: begin
          if (item.write_data_valid) begin
            latched_write_data    <= item.write_data;
            latched_write_strobes <= item.write_strobes;
            wready                <= 1'b1;
            state                 <= WR_UPDATE;
          end
        end
        WR_DATA_FIRST: begin
          if (item.write_addr_valid) begin
            latched_write_addr <= item.write_addr[ADDR_KEEP-1:0];
            awready            <= 1'b1;
            state              <= WR_UPDATE;
          end
        end
        WR_UPDATE: begin
          bvalid   <= 1'b1;
          wready   <= 1'b0;
          awready  <= 1'b0;
          ip_waddr <= latched_write_addr;
          ip_wdata <= latched_write_data;
          ip_wbe   <= latched_write_strobes;
          ip_wr    <= 1'b1;
          state    <= WR_DONE;
        end
        default: begin
          // hold bvalid and the IP write until the response is taken
          if (item.write_resp_ready) begin
            bvalid <= 1'b0;
            ip_wr  <= 1'b0;
            state  <= WR_IDLE;
          end
        end
      endcase
    end
  end

  always_comb begin
    wr.write_addr_ready      = awready;
    wr.write_data_ready      = wready;
    wr.write_resp_valid      = bvalid;
    wr.ip_write_addr         = albr_pkg::word_t'(ip_waddr);
    wr.ip_write_data         = ip_wdata;
    wr.ip_write_byte_enables = ip_wbe;
    wr.ip_write_strobe       = ip_wr;
  end

endmodule

/* rtl/albr_checker.sv */
// ----------------------------------------------------------------------------
// albr_sva
// Port-level checks of the bridge, bound to the top level.
// ----------------------------------------------------------------------------
module albr_sva (
  input logic            clk,
  input logic            rst,
  input logic            out_valid,
  input logic            out_ready,
  input logic            read_addr_ready,
  input logic            read_data_valid,
  input albr_pkg::word_t read_data,
  input logic            ip_read_strobe,
  input albr_pkg::word_t ip_write_data,
  input logic            write_resp_valid,
  input logic            ip_write_strobe
);

  // Stalled output transaction stays valid
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output transaction dropped while stalled");

  // Stalled output payload holds
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(read_data) && $stable(ip_write_data))
    else $error("output payload changed while stalled");

  // arready never overlaps the IP read pulse or rvalid
  a_rd_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(read_addr_ready && (read_data_valid || ip_read_strobe)))
    else $error("read machine flags overlap");

  // bvalid and the IP write enable rise and fall together
  a_wr_pair: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (write_resp_valid == ip_write_strobe))
    else $error("bvalid and IP write strobe disagree");

endmodule

bind axi_lite_slave_bridge_top albr_sva u_albr_sva (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .read_addr_ready  (read_addr_ready),
  .read_data_valid  (read_data_valid),
  .read_data        (read_data),
  .ip_read_strobe   (ip_read_strobe),
  .ip_write_data    (ip_write_data),
  .write_resp_valid (write_resp_valid),
  .ip_write_strobe  (ip_write_strobe)
);

/* verif/albr_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// albr_checker
// Watches the tick and result channels of the AXI-Lite slave bridge. Each
// accepted tick advances a local copy of the read and write machines. The
// registered outputs it predicts are queued. Each accepted result is compared
// field by field with the oldest queued prediction.
// ----------------------------------------------------------------------------
module albr_checker #(
  parameter int ADDR_WIDTH = albr_pkg::ADDR_WIDTH_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_write_en,
  input  albr_pkg::wait_t cfg_write_data,
  input  logic            in_valid,
  input  logic            in_ready,
  input  albr_pkg::item_t bus_tick,
  input  logic            out_valid,
  input  logic            out_ready,
  input  logic            read_addr_ready,
  input  logic            read_data_valid,
  input  albr_pkg::word_t read_data,
  input  logic            write_addr_ready,
  input  logic            write_data_ready,
  input  logic            write_resp_valid,
  input  albr_pkg::word_t ip_read_addr,
  input  logic            ip_read_strobe,
  input  albr_pkg::word_t ip_write_addr,
  input  albr_pkg::word_t ip_write_data,
  input  albr_pkg::strb_t ip_write_byte_enables,
  input  logic            ip_write_strobe,
  output int              fail_count,
  output int              pending
);

  localparam albr_pkg::word_t ADDR_MASK =
    (ADDR_WIDTH >= albr_pkg::FIELD_W) ? '1 :
    albr_pkg::word_t'((64'd1 << ADDR_WIDTH) - 64'd1);

  typedef enum logic [2:0] {RD_IDLE, RD_LATCH, RD_WAIT, RD_RESP, RD_HOLD} rd_phase_t;
  typedef enum logic [2:0] {
    WR_IDLE, WR_ADDR_FIRST, WR_DATA_FIRST, WR_UPDATE, WR_HOLD
  } wr_phase_t;

  // Registered outputs of the bridge, as seen on the result channel
  typedef struct packed {
    logic            read_addr_ready;
    logic            read_data_valid;
    albr_pkg::word_t read_data;
    logic            write_addr_ready;
    logic            write_data_ready;
    logic            write_resp_valid;
    albr_pkg::word_t ip_read_addr;
    logic            ip_read_strobe;
    albr_pkg::word_t ip_write_addr;
    albr_pkg::word_t ip_write_data;
    albr_pkg::strb_t ip_write_byte_enables;
    logic            ip_write_strobe;
  } bus_view_t;

  // Shadow state of both machines
  rd_phase_t       rd_phase;
  wr_phase_t       wr_phase;
  albr_pkg::wait_t wait_cycles;
  albr_pkg::wait_t wait_cnt;
  albr_pkg::word_t rd_addr_q;
  albr_pkg::word_t wr_addr_q;
  albr_pkg::word_t wr_data_q;
  albr_pkg::strb_t wr_strb_q;
  bus_view_t       regs_q;

  bus_view_t bridge_outputs_q[$];

  task automatic clear_bridge();
    rd_phase    = RD_IDLE;
    wr_phase    = WR_IDLE;
    wait_cycles = albr_pkg::READ_WAIT_RESET;
    wait_cnt    = '0;
    rd_addr_q   = '0;
    wr_addr_q   = '0;
    wr_data_q   = '0;
    wr_strb_q   = '0;
    regs_q      = '0;
  endtask

  // One bus tick through both machines; regs_q ends up as the next outputs
  task automatic advance_bridge(input albr_pkg::item_t t);
    case (rd_phase)
      RD_IDLE: begin
        wait_cnt = '0;
        regs_q.read_data_valid = 1'b0;
        if (t.read_addr_valid) begin
          rd_addr_q = t.read_addr & ADDR_MASK;
          regs_q.read_addr_ready = 1'b1;
          rd_phase = RD_LATCH;
        end
      end
      RD_LATCH: begin
        regs_q.read_addr_ready = 1'b0;
        regs_q.ip_read_addr    = rd_addr_q;
        regs_q.ip_read_strobe  = 1'b1;
        rd_phase = RD_WAIT;
      end
      RD_WAIT: begin
        regs_q.ip_read_strobe = 1'b0;
        regs_q.read_data      = t.ip_read_data;
        // a wait count of zero wraps the 8-bit compare value to 255
        if (wait_cnt == albr_pkg::wait_t'(wait_cycles - 8'd1)) begin
          regs_q.read_data_valid = 1'b1;
          rd_phase = RD_RESP;
        end else begin
          wait_cnt = wait_cnt + 8'd1;
        end
      end
      RD_RESP: rd_phase = RD_HOLD;
      default: begin
        if (t.read_ready) begin
          regs_q.read_data_valid = 1'b0;
          rd_phase = RD_IDLE;
        end
      end
    endcase

    case (wr_phase)
      WR_IDLE: begin
        if (t.write_addr_valid) begin
          wr_addr_q = t.write_addr & ADDR_MASK;
          regs_q.write_addr_ready = 1'b1;
        end
        if (t.write_data_valid) begin
          wr_data_q = t.write_data;
          wr_strb_q = t.write_strobes;
          regs_q.write_data_ready = 1'b1;
        end
        if (t.write_addr_valid && t.write_data_valid) begin
          wr_phase = WR_UPDATE;
        end else if (t.write_addr_valid) begin
          wr_phase = WR_ADDR_FIRST;
        end else if (t.write_data_valid) begin
          wr_phase = WR_DATA_FIRST;
        end else begin
          regs_q.write_addr_ready = 1'b0;
          regs_q.write_data_ready = 1'b0;
          regs_q.write_resp_valid = 1'b0;
          regs_q.ip_write_strobe  = 1'b0;
        end
      end
      WR_ADDR_FIRST: begin
        if (t.write_data_valid) begin
          wr_data_q = t.write_data;
          wr_strb_q = t.write_strobes;
          regs_q.write_data_ready = 1'b1;
          wr_phase = WR_UPDATE;
        end
      end
      WR_DATA_FIRST: begin
        if (t.write_addr_valid) begin
          wr_addr_q = t.write_addr & ADDR_MASK;
          regs_q.write_addr_ready = 1'b1;
          wr_phase = WR_UPDATE;
        end
      end
      WR_UPDATE: begin
        regs_q.write_resp_valid      = 1'b1;
        regs_q.write_data_ready      = 1'b0;
        regs_q.write_addr_ready      = 1'b0;
        regs_q.ip_write_addr         = wr_addr_q;
        regs_q.ip_write_data         = wr_data_q;
        regs_q.ip_write_byte_enables = wr_strb_q;
        regs_q.ip_write_strobe       = 1'b1;
        wr_phase = WR_HOLD;
      end
      default: begin
        if (t.write_resp_ready) begin
          regs_q.write_resp_valid = 1'b0;
          regs_q.ip_write_strobe  = 1'b0;
          wr_phase = WR_IDLE;
        end
      end
    endcase
  endtask

  task automatic check_field(input string name, input albr_pkg::word_t want,
                             input albr_pkg::word_t got);
    if (want !== got) begin
      $error("%s: expected %h, actual %h", name, want, got);
      fail_count++;
    end
  endtask

  // Channel monitor: predict on accepted ticks, compare on accepted results
  always @(posedge clk) begin
    bus_view_t want;
    if (rst) begin
      clear_bridge();
      bridge_outputs_q.delete();
    end else begin
      if (cfg_write_en) begin
        wait_cycles = cfg_write_data;
      end
      if (in_valid && in_ready) begin
        advance_bridge(bus_tick);
        bridge_outputs_q.push_back(regs_q);
      end
      if (out_valid && out_ready) begin
        if (bridge_outputs_q.size() == 0) begin
          $error("result transaction with no tick outstanding");
          fail_count++;
        end else begin
          want = bridge_outputs_q.pop_front();
          check_field("read_addr_ready", albr_pkg::word_t'(want.read_addr_ready),
                      albr_pkg::word_t'(read_addr_ready));
          check_field("read_data_valid", albr_pkg::word_t'(want.read_data_valid),
                      albr_pkg::word_t'(read_data_valid));
          check_field("read_data", want.read_data, read_data);
          check_field("write_addr_ready", albr_pkg::word_t'(want.write_addr_ready),
                      albr_pkg::word_t'(write_addr_ready));
          check_field("write_data_ready", albr_pkg::word_t'(want.write_data_ready),
                      albr_pkg::word_t'(write_data_ready));
          check_field("write_resp_valid", albr_pkg::word_t'(want.write_resp_valid),
                      albr_pkg::word_t'(write_resp_valid));
          check_field("ip_read_addr", want.ip_read_addr, ip_read_addr);
          check_field("ip_read_strobe", albr_pkg::word_t'(want.ip_read_strobe),
                      albr_pkg::word_t'(ip_read_strobe));
          check_field("ip_write_addr", want.ip_write_addr, ip_write_addr);
          check_field("ip_write_data", want.ip_write_data, ip_write_data);
          check_field("ip_write_byte_enables",
                      albr_pkg::word_t'(want.ip_write_byte_enables),
                      albr_pkg::word_t'(ip_write_byte_enables));
          check_field("ip_write_strobe", albr_pkg::word_t'(want.ip_write_strobe),
                      albr_pkg::word_t'(ip_write_strobe));
        end
      end
    end
    pending = bridge_outputs_q.size();
  end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the AXI-Lite slave bridge. A directed run of bus ticks covers
// each address/data ordering and the field extremes, then random ticks run
// under several read wait counts, including the shortest and the wrapping
// zero count. Both channels stall at random; the checker beside the block
// predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int IDLE_LIMIT = 1000;

  logic            clk;
  logic            rst;
  logic            cfg_write_en;
  albr_pkg::wait_t cfg_write_data;
  logic            in_valid;
  logic            in_ready;
  albr_pkg::item_t bus_tick;
  logic            out_valid;
  logic            out_ready;
  logic            read_addr_ready;
  logic            read_data_valid;
  albr_pkg::word_t read_data;
  logic            write_addr_ready;
  logic            write_data_ready;
  logic            write_resp_valid;
  albr_pkg::word_t ip_read_addr;
  logic            ip_read_strobe;
  albr_pkg::word_t ip_write_addr;
  albr_pkg::word_t ip_write_data;
  albr_pkg::strb_t ip_write_byte_enables;
  logic            ip_write_strobe;
  int              fail_count;
  int              pending;

  bit calm;      // no stalls on either side while set
  bit hold_req;  // asks the result side for one long hold-off

  axi_lite_slave_bridge_top u_top (
    .clk                   (clk),
    .rst                   (rst),
    .cfg_write_en          (cfg_write_en),
    .cfg_write_data        (cfg_write_data),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .read_addr_valid       (bus_tick.read_addr_valid),
    .read_addr             (bus_tick.read_addr),
    .read_ready            (bus_tick.read_ready),
    .write_addr_valid      (bus_tick.write_addr_valid),
    .write_addr            (bus_tick.write_addr),
    .write_data_valid      (bus_tick.write_data_valid),
    .write_data            (bus_tick.write_data),
    .write_strobes         (bus_tick.write_strobes),
    .write_resp_ready      (bus_tick.write_resp_ready),
    .ip_read_data          (bus_tick.ip_read_data),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .read_addr_ready       (read_addr_ready),
    .read_data_valid       (read_data_valid),
    .read_data             (read_data),
    .write_addr_ready      (write_addr_ready),
    .write_data_ready      (write_data_ready),
    .write_resp_valid      (write_resp_valid),
    .ip_read_addr          (ip_read_addr),
    .ip_read_strobe        (ip_read_strobe),
    .ip_write_addr         (ip_write_addr),
    .ip_write_data         (ip_write_data),
    .ip_write_byte_enables (ip_write_byte_enables),
    .ip_write_strobe       (ip_write_strobe)
  );

  albr_checker u_chk (.*);

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit stall_now();
    return !calm && ($urandom_range(0, 99) < 11);
  endfunction

  function automatic albr_pkg::item_t mk_tick(
    bit arv, albr_pkg::word_t ara, bit rr, bit awv, albr_pkg::word_t awa,
    bit wv, albr_pkg::word_t wd, albr_pkg::strb_t ws, bit br, albr_pkg::word_t ipd);
    albr_pkg::item_t t;
    t.read_addr_valid  = arv;
    t.read_addr        = ara;
    t.read_ready       = rr;
    t.write_addr_valid = awv;
    t.write_addr       = awa;
    t.write_data_valid = wv;
    t.write_data       = wd;
    t.write_strobes    = ws;
    t.write_resp_ready = br;
    t.ip_read_data     = ipd;
    return t;
  endfunction

  function automatic albr_pkg::item_t random_tick();
    albr_pkg::item_t t;
    t.read_addr_valid  = $urandom_range(0, 99) < 40;
    t.read_addr        = $urandom;
    t.read_ready       = $urandom_range(0, 99) < 50;
    t.write_addr_valid = $urandom_range(0, 99) < 40;
    t.write_addr       = $urandom;
    t.write_data_valid = $urandom_range(0, 99) < 40;
    t.write_data       = $urandom;
    t.write_strobes    = albr_pkg::strb_t'($urandom_range(0, 15));
    t.write_resp_ready = $urandom_range(0, 99) < 50;
    t.ip_read_data     = $urandom;
    return t;
  endfunction

  // Offer one tick; called and returns at a falling edge
  task automatic send_tick(input albr_pkg::item_t t);
    while (stall_now()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    bus_tick <= t;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic random_ticks(input int n);
    for (int i = 0; i < n; i++) begin
      send_tick(random_tick());
    end
  endtask

  // Drain every outstanding result, then write the read wait count
  task automatic set_read_wait(input albr_pkg::wait_t w);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    @(negedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= w;
    @(negedge clk);
    cfg_write_en   <= 1'b0;
  endtask

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        for (int n = 1; n < 60; n++) @(negedge clk);
      end else begin
        out_ready <= !stall_now();
      end
    end
  end

  // Watchdog on cycles with no transaction on either channel
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("FAIL axi_lite_slave_bridge_top");
    $finish;
  end

  // Stimulus
  initial begin
    rst            <= 1'b1;
    cfg_write_en   <= 1'b0;
    cfg_write_data <= '0;
    in_valid       <= 1'b0;
    bus_tick       <= '0;
    calm     = 1'b0;
    hold_req = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed, reset wait count: address and data together, extremes
    send_tick(mk_tick(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_tick(mk_tick(1, '1, 0, 1, '1, 1, '1, '1, 0, 0));
    send_tick(mk_tick(0, 0, 0, 0, 0, 0, 0, 0, 0, '1));
    send_tick(mk_tick(0, 0, 0, 0, 0, 0, 0, 0, 0, 32'hA5A5_A5A5));
    send_tick(mk_tick(0, 0, 0, 0, 0, 0, 0, 0, 0, '1));
    send_tick(mk_tick(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_tick(mk_tick(0, 0, 1, 0, 0, 0, 0, 0, 1, 0));
    // address before data, read overlapping the write
    send_tick(mk_tick(1, 0, 0, 1, 0, 0, '1, '1, 0, 0));
    send_tick(mk_tick(0, '1, 1, 0, '1, 0, 0, 0, 1, 32'h5A5A_5A5A));
    send_tick(mk_tick(0, 0, 0, 0, 0, 1, 0, 0, 0, 0));
    send_tick(mk_tick(0, 0, 0, 0, 0, 0, 0, 0, 0, '1));
    send_tick(mk_tick(0, 0, 1, 0, 0, 0, 0, 0, 1, 0));
    send_tick(mk_tick(0, 0, 1, 0, 0, 0, 0, 0, 0, 0));
    // data before address
    send_tick(mk_tick(0, 0, 0, 0, 0, 1, 32'h5A5A_5A5A, 4'h5, 0, 0));
    send_tick(mk_tick(1, 32'h8000_0001, 0, 0, '1, 1, 0, 4'hA, 1, 0));
    send_tick(mk_tick(0, 0, 0, 1, 32'h1234_5678, 0, 0, 0, 0, 32'h8000_0000));
    send_tick(mk_tick(0, 0, 0, 0, 0, 0, 0, 0, 0, 32'h0000_0001));
    send_tick(mk_tick(0, 0, 0, 0, 0, 0, 0, 0, 1, '1));
    send_tick(mk_tick(0, 0, 1, 0, 0, 0, 0, 0, 1, 0));
    send_tick(mk_tick(0, 0, 1, 0, 0, 0, 0, 0, 0, 0));
    send_tick(mk_tick(0, 0, 1, 1, '1, 1, '1, '1, 1, 0));
    send_tick(mk_tick(0, 0, 0, 0, 0, 0, 0, 0, 1, 0));

    // Shortest wait, with one long result-side hold-off
    set_read_wait(8'd1);
    hold_req = 1'b1;
    random_ticks(60);

    // Wrapping zero count: the longest wait of all
    set_read_wait(8'd0);
    random_ticks(270);

    // Moderate wait, first with no stalls on either side, then with stalls
    set_read_wait(albr_pkg::wait_t'($urandom_range(3, 8)));
    calm = 1'b1;
    random_ticks(100);
    calm = 1'b0;
    random_ticks(40);

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (5) @(negedge clk);
    if (fail_count == 0) begin
      $display("PASS axi_lite_slave_bridge_top");
    end else begin
      $display("FAIL axi_lite_slave_bridge_top");
    end
    $finish;
  end

endmodule
